FILE: hw/rtl/dqbe_pkg.sv
// Shared types and constants for the dual queue balanced enqueue unit.
// No dependencies.
package dqbe_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int CNT_OUT_W       = 4;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_ADD        = 2'd0;
  localparam func_t FUNC_REM_FIRST  = 2'd1;
  localparam func_t FUNC_REM_SECOND = 2'd2;
  localparam func_t FUNC_NOP        = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STAT_DONE  = 2'd0;
  localparam status_t STAT_DROP  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic load;
  } dqbe_cmd_t;

endpackage

FILE: hw/rtl/dual_queue_balanced_enqueue_unit.sv
// Top level of the dual queue balanced enqueue unit.
// Depends on dqbe_pkg, dqbe_ctrl and dqbe_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | func, entry_data
//   out     | out_valid / out_ready| status, queue_used, removed_data,
//           |                      | count_first, count_second
//
// One transaction per cycle; the result is registered and shows the cycle
// after acceptance. Both queue updates and the result register load in that
// single edge. A held result blocks input only while out_ready is low.
// Reset empties both queues; entry storage is not cleared.
module dual_queue_balanced_enqueue_unit #(
  parameter int QUEUE_DEPTH = dqbe_pkg::QUEUE_DEPTH_DEF,
  parameter int ENTRY_WIDTH = dqbe_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dqbe_pkg::func_t                func,
  input  logic [dqbe_pkg::DATA_W-1:0]    entry_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dqbe_pkg::status_t              status,
  output logic                           queue_used,
  output logic [dqbe_pkg::DATA_W-1:0]    removed_data,
  output logic [dqbe_pkg::CNT_OUT_W-1:0] count_first,
  output logic [dqbe_pkg::CNT_OUT_W-1:0] count_second
);
  import dqbe_pkg::*;

  dqbe_cmd_t cmd;

  dqbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dqbe_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .entry_data   (entry_data),
    .status       (status),
    .queue_used   (queue_used),
    .removed_data (removed_data),
    .count_first  (count_first),
    .count_second (count_second)
  );

endmodule

FILE: hw/rtl/dqbe_ctrl.sv
// Handshake controller: accepts transactions and tracks the result register.
// Depends on dqbe_pkg.
module dqbe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dqbe_pkg::dqbe_cmd_t cmd
);
  import dqbe_pkg::*;

  ctrl_state_t state, state_next;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTRL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CTRL_IDLE: begin
        if (accept) state_next = CTRL_HOLD;
      end
      CTRL_HOLD: begin
        if (out_ready && !accept) state_next = CTRL_IDLE;
      end
      default: state_next = CTRL_IDLE;
    endcase
  end

  always_comb begin
    out_valid = 1'b0;
    in_ready  = 1'b0;
    unique case (state)
      CTRL_IDLE: begin
        in_ready = 1'b1;
      end
      CTRL_HOLD: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        out_valid = 1'b0;
        in_ready  = 1'b0;
      end
    endcase
    cmd.load = in_valid && in_ready;
  end

endmodule

FILE: hw/rtl/dqbe_datapath.sv
// Datapath: two shift-register queues, their counts and the result register.
// Depends on dqbe_pkg.
module dqbe_datapath #(
  parameter int QUEUE_DEPTH = dqbe_pkg::QUEUE_DEPTH_DEF,
  parameter int ENTRY_WIDTH = dqbe_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dqbe_pkg::dqbe_cmd_t               cmd,
  input  dqbe_pkg::func_t                   func,
  input  logic [dqbe_pkg::DATA_W-1:0]       entry_data,
  output dqbe_pkg::status_t                 status,
  output logic                              queue_used,
  output logic [dqbe_pkg::DATA_W-1:0]       removed_data,
  output logic [dqbe_pkg::CNT_OUT_W-1:0]    count_first,
  output logic [dqbe_pkg::CNT_OUT_W-1:0]    count_second
);
  import dqbe_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic [ENTRY_WIDTH-1:0] first_entries  [QUEUE_DEPTH];
  logic [ENTRY_WIDTH-1:0] second_entries [QUEUE_DEPTH];
  logic [CW-1:0]          first_count, second_count;
  logic [CW-1:0]          first_count_next, second_count_next;

  logic                   push1, push2, pop1, pop2;
  logic                   full1, full2;
  status_t                status_next;
  logic                   used_next;
  logic [DATA_W-1:0]      removed_next;
  logic [ENTRY_WIDTH-1:0] wr_data;

  assign full1   = (first_count == DEPTH_C);
  assign full2   = (second_count == DEPTH_C);
  assign wr_data = ENTRY_WIDTH'(entry_data);

  always_comb begin
    push1        = 1'b0;
    push2        = 1'b0;
    pop1         = 1'b0;
    pop2         = 1'b0;
    status_next  = STAT_DONE;
    used_next    = 1'b0;
    removed_next = '0;
    case (func)
      FUNC_ADD: begin
        if (full1 && full2) begin
          status_next = STAT_DROP;
        end else if (first_count > second_count) begin
          push2     = 1'b1;
          used_next = 1'b1;
        end else begin
          push1 = 1'b1;
        end
      end
      FUNC_REM_FIRST: begin
        if (first_count == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          pop1         = 1'b1;
          removed_next = DATA_W'(first_entries[0]);
        end
      end
      FUNC_REM_SECOND: begin
        used_next = 1'b1;
        if (second_count == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          pop2         = 1'b1;
          removed_next = DATA_W'(second_entries[0]);
        end
      end
      default: begin
        status_next = STAT_DONE;
      end
    endcase
  end

  always_comb begin
    first_count_next  = first_count;
    second_count_next = second_count;
    if (push1) first_count_next = first_count + CW'(1);
    if (pop1)  first_count_next = first_count - CW'(1);
    if (push2) second_count_next = second_count + CW'(1);
    if (pop2)  second_count_next = second_count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
    end else if (cmd.load) begin
      first_count  <= first_count_next;
      second_count <= second_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status       <= status_next;
      queue_used   <= used_next;
      removed_data <= removed_next;
    end
  end

  // write at the tail, or shift toward the head on a removal
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.load) begin
        if (push1 && first_count == CW'(i)) begin
          first_entries[i] <= wr_data;
        end else if (pop1 && i < QUEUE_DEPTH - 1) begin
          first_entries[i] <= first_entries[(i + 1) % QUEUE_DEPTH];
        end
        if (push2 && second_count == CW'(i)) begin
          second_entries[i] <= wr_data;
        end else if (pop2 && i < QUEUE_DEPTH - 1) begin
          second_entries[i] <= second_entries[(i + 1) % QUEUE_DEPTH];
        end
      end
    end
  end

  assign count_first  = CNT_OUT_W'(first_count);
  assign count_second = CNT_OUT_W'(second_count);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    first_count <= DEPTH_C && second_count <= DEPTH_C)
    else $error("queue count beyond depth");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && func == FUNC_ADD && !(full1 && full2)) |=>
    ((CW + 1)'(first_count) + (CW + 1)'(second_count) ==
     $past((CW + 1)'(first_count) + (CW + 1)'(second_count)) + (CW + 1)'(1)))
    else $error("add did not grow total count by one");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && func == FUNC_REM_FIRST && first_count == '0) |=>
    (status == STAT_EMPTY && removed_data == '0 && first_count == '0))
    else $error("removal from empty queue one misreported");

  a_drop_keeps: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && func == FUNC_ADD && full1 && full2) |=>
    (status == STAT_DROP && !queue_used && full1 && full2))
    else $error("dropped add changed state");
`endif

endmodule

FILE: verif/dual_queue_balanced_enqueue_unit_tb.sv
// Self-checking testbench for dual_queue_balanced_enqueue_unit: balanced adds, removals, drops.
// Predicts every result with its own pair of queues and checks it field by field.
// Depends on dqbe_pkg and the dual_queue_balanced_enqueue_unit RTL.
module dual_queue_balanced_enqueue_unit_tb;
  import dqbe_pkg::*;

  localparam int STUCK_LIMIT = 1000;
  localparam int N_RANDOM    = 400;
  localparam int N_STEADY    = 60;

  typedef struct {
    func_t             op;
    logic [DATA_W-1:0] word;
    bit                drain;
    bit                steady;
  } queue_op_t;

  typedef struct packed {
    status_t              status;
    logic                 used;
    logic [DATA_W-1:0]    removed;
    logic [CNT_OUT_W-1:0] n_first;
    logic [CNT_OUT_W-1:0] n_second;
  } queue_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  func_t                func = FUNC_ADD;
  logic [DATA_W-1:0]    entry_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  status_t              status;
  logic                 queue_used;
  logic [DATA_W-1:0]    removed_data;
  logic [CNT_OUT_W-1:0] count_first;
  logic [CNT_OUT_W-1:0] count_second;

  queue_op_t         pending_ops[$];
  queue_result_t     expected_results[$];
  logic [DATA_W-1:0] q_one[$];
  logic [DATA_W-1:0] q_two[$];

  bit results_drained = 1'b1;
  bit steady = 1'b0;
  int errors = 0;
  int stuck = 0;
  int src_gap = 0;
  int src_cycles = 0;
  int src_idle_pct = 20;
  int sink_stall = 0;
  int sink_cycles = 0;
  int sink_idle_pct = 20;

  dual_queue_balanced_enqueue_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .entry_data(entry_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .queue_used(queue_used),
    .removed_data(removed_data),
    .count_first(count_first),
    .count_second(count_second)
  );

  always #10 clk = ~clk;

  function automatic queue_result_t balance_and_dequeue(func_t op, logic [DATA_W-1:0] word);
    queue_result_t r;
    r = '0;
    r.status = STAT_DONE;
    case (op)
      FUNC_ADD: begin
        if (q_one.size() >= QUEUE_DEPTH_DEF && q_two.size() >= QUEUE_DEPTH_DEF) begin
          r.status = STAT_DROP;
        end else if (q_one.size() > q_two.size()) begin
          q_two.push_back(word);
          r.used = 1'b1;
        end else begin
          q_one.push_back(word);
        end
      end
      FUNC_REM_FIRST: begin
        if (q_one.size() == 0) r.status = STAT_EMPTY;
        else r.removed = q_one.pop_front();
      end
      FUNC_REM_SECOND: begin
        r.used = 1'b1;
        if (q_two.size() == 0) r.status = STAT_EMPTY;
        else r.removed = q_two.pop_front();
      end
      default: ;
    endcase
    r.n_first  = CNT_OUT_W'(q_one.size());
    r.n_second = CNT_OUT_W'(q_two.size());
    return r;
  endfunction

  function automatic int idle_mix();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 45;
    endcase
  endfunction

  task automatic queue_op(func_t op, logic [DATA_W-1:0] word, bit drain = 1'b0,
                          bit calm = 1'b0);
    queue_op_t t;
    t.op = op;
    t.word = word;
    t.drain = drain;
    t.steady = calm;
    pending_ops.push_back(t);
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // stimulus driver
  always @(posedge clk) begin
    queue_op_t nxt;
    bit        accepted;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) expected_results.push_back(balance_and_dequeue(func, entry_data));
      src_cycles++;
      if (src_cycles % 64 == 0) src_idle_pct = idle_mix();
      if (!in_valid || accepted) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_ops[0].drain && (accepted || !results_drained)) begin
          in_valid <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < src_idle_pct) begin
          src_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          nxt = pending_ops.pop_front();
          in_valid <= 1'b1;
          func <= nxt.op;
          entry_data <= nxt.word;
          if (nxt.steady) steady <= 1'b1;
        end
      end
    end
  end

  always @(negedge clk) results_drained <= (expected_results.size() == 0);

  // result monitor
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual status %0d", $time,
                   status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", DATA_W'(exp_r.status), DATA_W'(status));
          check_field("queue_used", DATA_W'(exp_r.used), DATA_W'(queue_used));
          check_field("removed_data", exp_r.removed, removed_data);
          check_field("count_first", DATA_W'(exp_r.n_first), DATA_W'(count_first));
          check_field("count_second", DATA_W'(exp_r.n_second), DATA_W'(count_second));
        end
      end
      sink_cycles++;
      if (sink_cycles % 64 == 32) sink_idle_pct = idle_mix();
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < sink_idle_pct) begin
        sink_stall = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int add_pct;
    int r;
    func_t op;

    // directed: empty removals, unused code, fill both queues, drop, drain a little
    queue_op(FUNC_REM_FIRST, 32'hFFFF_FFFF);
    queue_op(FUNC_REM_SECOND, 32'h0);
    queue_op(FUNC_NOP, 32'hDEAD_BEEF);
    queue_op(FUNC_ADD, 32'h0000_0000);
    queue_op(FUNC_ADD, 32'hFFFF_FFFF);
    queue_op(FUNC_ADD, 32'hA5A5_A5A5);
    queue_op(FUNC_ADD, 32'h5A5A_5A5A);
    queue_op(FUNC_ADD, 32'h8000_0000);
    queue_op(FUNC_ADD, 32'h0000_0001);
    for (int i = 0; i < 10; i++) queue_op(FUNC_ADD, $urandom());
    queue_op(FUNC_ADD, 32'h1234_5678);
    queue_op(FUNC_REM_FIRST, 32'h0);
    queue_op(FUNC_REM_SECOND, 32'h0);
    queue_op(FUNC_ADD, 32'h7FFF_FFFF);
    queue_op(FUNC_NOP, 32'hFFFF_FFFF);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 20;
          1: add_pct = 50;
          default: add_pct = 85;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 5) op = FUNC_NOP;
      else if (r < 5 + add_pct * 95 / 100) op = FUNC_ADD;
      else if ($urandom_range(0, 1) == 0) op = FUNC_REM_FIRST;
      else op = FUNC_REM_SECOND;
      queue_op(op, $urandom(), i == 0 || (i % 40 == 0 && $urandom_range(0, 2) == 0),
               i >= N_RANDOM - N_STEADY);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (pending_ops.size() == 0 && !in_valid);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
